### hdl/mlpc_pkg.sv
// Shared types and constants of the multi-LED pattern controller.
package mlpc_pkg;

	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int IDX_FLD_W  = 4;
	localparam int MODE_W     = 3;
	localparam int LVL_W      = 8;
	localparam int COUNT_W    = 9;
	localparam int PERIOD_W   = 8;
	localparam int PULSE_W    = 6;
	localparam int STEP_W     = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF    = 3'd0,
		MODE_ON     = 3'd1,
		MODE_SLOW   = 3'd2,
		MODE_NORMAL = 3'd3,
		MODE_FAST   = 3'd4,
		MODE_ONCE   = 3'd5,
		MODE_TWICE  = 3'd6,
		MODE_THRICE = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		REG_SLOW   = 2'd0,
		REG_NORMAL = 2'd1,
		REG_FAST   = 2'd2,
		REG_PULSE  = 2'd3
	} reg_idx_t;

	localparam logic [PERIOD_W-1:0] SLOW_RST   = 8'd10;
	localparam logic [PERIOD_W-1:0] NORMAL_RST = 8'd5;
	localparam logic [PERIOD_W-1:0] FAST_RST   = 8'd1;
	localparam logic [PULSE_W-1:0]  PULSE_RST  = 6'd2;

	typedef struct packed {
		logic [PERIOD_W-1:0] slow_period;
		logic [PERIOD_W-1:0] normal_period;
		logic [PERIOD_W-1:0] fast_period;
		logic [PULSE_W-1:0]  pulse_period;
	} cfg_t;

endpackage

### hdl/mlpc_if.sv
// Request and response channel interfaces of the multi-LED pattern controller.
interface mlpc_req_if;
	import mlpc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [IDX_FLD_W-1:0] led_index;
	logic [MODE_W-1:0]    mode;
	modport source (output valid, action, led_index, mode, input ready);
	modport sink (input valid, action, led_index, mode, output ready);
endinterface

interface mlpc_rsp_if;
	import mlpc_pkg::*;
	logic             valid;
	logic             ready;
	logic [LVL_W-1:0] led_levels;
	logic             error;
	modport source (output valid, led_levels, error, input ready);
	modport sink (input valid, led_levels, error, output ready);
endinterface

### hdl/multi_led_pattern_controller.sv
// Top level of the multi-LED pattern controller: sequencer, LED state and result register.
//
//  Channel  Kind          Direction  Carries
//  req      valid/ready   in         action, led_index, mode
//  rsp      valid/ready   out        led_levels, error
//  apb      APB write/rd  in         slow, normal, fast and pulse periods
//
// A set-mode request goes from acceptance to the finish state, which then loads the response register.
// A tick request visits the LEDs in index order through one sequencer: an off,
// on or blink LED passes through the load state only, a pulse-mode LED also waits
// in the remainder state, because the shared remainder unit resolves one bit of
// the 9-bit counter per cycle.
// Reset clears all LED state at once; the block is ready right after reset.
// A request is taken whenever the sequencer is idle, even while an earlier
// response waits; the new response then waits in the finish state.
module multi_led_pattern_controller #(
	parameter int NUM_LEDS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mlpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [mlpc_pkg::DATA_W-1:0]  pwdata,
	output logic [mlpc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	mlpc_req_if.sink                     req,
	mlpc_rsp_if.source                   rsp
);
	import mlpc_pkg::*;

	localparam int IW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_MOD  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	cfg_t               cfg;
	state_t             state_q;
	logic [IW-1:0]      idx_q;
	logic               err_q;
	logic [COUNT_W-1:0] work_cnt_q;
	logic               out_valid_q;
	logic [LVL_W-1:0]   out_levels_q;
	logic               out_err_q;

	// Per-LED state. The step logic reads each LED only at the sequencer index.
	mode_t              mode_q   [NUM_LEDS];
	logic [COUNT_W-1:0] count_q  [NUM_LEDS];
	logic               toggle_q [NUM_LEDS];
	logic               pin_q    [NUM_LEDS];

	logic               req_fire;
	logic               set_ok;
	logic [IW-1:0]      set_idx;
	logic               last_led;
	logic               fin_load;
	mode_t              cur_mode;
	logic [COUNT_W-1:0] cnt_inc;
	logic [PERIOD_W-1:0] blink_raw;
	logic [PERIOD_W-1:0] blink_per;
	logic               blink_hit;
	logic               is_pulse;
	logic [PULSE_W-1:0] pulse_per;
	logic [COUNT_W-1:0] pulse_limit;
	logic               mod_start;
	logic               mod_done;
	logic [PULSE_W-1:0] mod_rem;
	logic [LVL_W-1:0]   levels;

	mlpc_apb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The remainder unit decides whether the pulse counter sits on a multiple
	// of the pulse period.
	mlpc_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cnt_inc),
		.divisor  (pulse_per),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign set_idx   = req.led_index[IW-1:0];
	assign set_ok    = req_fire && req.action &&
	                   ({1'b0, req.led_index} < (IDX_FLD_W + 1)'(NUM_LEDS));
	assign last_led  = (idx_q == IW'(NUM_LEDS - 1));
	assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	// Step logic for the LED at the sequencer index. A zero period acts as one.
	always_comb begin
		cur_mode = mode_q[idx_q];
		cnt_inc  = count_q[idx_q] + COUNT_W'(1);
		case (cur_mode)
			MODE_SLOW:   blink_raw = cfg.slow_period;
			MODE_NORMAL: blink_raw = cfg.normal_period;
			default:     blink_raw = cfg.fast_period;
		endcase
		blink_per = (blink_raw == '0) ? PERIOD_W'(1) : blink_raw;
		blink_hit = (cnt_inc >= COUNT_W'(blink_per));
		is_pulse  = (cur_mode inside {MODE_ONCE, MODE_TWICE, MODE_THRICE});
		pulse_per = (cfg.pulse_period == '0) ? PULSE_W'(1) : cfg.pulse_period;
		// Two pulse periods for each pulse of the mode.
		case (cur_mode)
			MODE_ONCE:  pulse_limit = COUNT_W'({pulse_per, 1'b0});
			MODE_TWICE: pulse_limit = COUNT_W'({pulse_per, 2'b00});
			default:    pulse_limit = COUNT_W'({pulse_per, 2'b00}) +
			                          COUNT_W'({pulse_per, 1'b0});
		endcase
	end

	assign mod_start = (state_q == ST_LOAD) && is_pulse;

	// LED state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				mode_q[i]   <= MODE_OFF;
				count_q[i]  <= '0;
				toggle_q[i] <= 1'b0;
				pin_q[i]    <= 1'b0;
			end
		end else begin
			// A set-mode request replaces the mode and restarts the counter;
			// the pin keeps its level until the next tick.
			if (set_ok) begin
				mode_q[set_idx]  <= mode_t'(req.mode);
				count_q[set_idx] <= '0;
			end
			if (state_q == ST_LOAD) begin
				case (cur_mode)
					MODE_OFF: pin_q[idx_q] <= 1'b0;
					MODE_ON:  pin_q[idx_q] <= 1'b1;
					MODE_SLOW, MODE_NORMAL, MODE_FAST: begin
						if (blink_hit) begin
							count_q[idx_q]  <= '0;
							toggle_q[idx_q] <= ~toggle_q[idx_q];
							pin_q[idx_q]    <= ~toggle_q[idx_q];
						end else begin
							count_q[idx_q] <= cnt_inc;
						end
					end
					default: ;
				endcase
			end
			// Pulse modes finish once the remainder is known. At the end of the
			// sequence the mode drops to off while the pin holds its level.
			if ((state_q == ST_MOD) && mod_done) begin
				if (mod_rem == '0) begin
					toggle_q[idx_q] <= ~toggle_q[idx_q];
					pin_q[idx_q]    <= ~toggle_q[idx_q];
				end
				if (work_cnt_q >= pulse_limit) begin
					count_q[idx_q] <= '0;
					mode_q[idx_q]  <= MODE_OFF;
				end else begin
					count_q[idx_q] <= work_cnt_q;
				end
			end
		end
	end

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						idx_q <= '0;
						if (req.action) begin
							err_q   <= !set_ok;
							state_q <= ST_FIN;
						end else begin
							err_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					if (is_pulse) begin
						state_q <= ST_MOD;
					end else if (last_led) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						if (last_led) begin
							state_q <= ST_FIN;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= ST_LOAD;
						end
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			work_cnt_q <= cnt_inc;
		end
		if (fin_load) begin
			out_levels_q <= levels;
			out_err_q    <= err_q;
		end
	end

	// Only the first eight LEDs have a bit in the level vector.
	for (genvar g = 0; g < LVL_W; g++) begin : g_lvl
		if (g < NUM_LEDS) begin : g_on
			assign levels[g] = pin_q[g];
		end else begin : g_off
			assign levels[g] = 1'b0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.led_levels = out_levels_q;
	assign rsp.error      = out_err_q;

	// The remainder unit answers only while the sequencer waits for it.
	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MOD))
		else $error("remainder result outside the pulse wait");

	// A set-mode request goes straight to the finish state.
	a_set_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.action) |=> (state_q == ST_FIN))
		else $error("set-mode request did not finish at once");

	// The sequencer index never leaves the LED range.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (idx_q <= IW'(NUM_LEDS - 1)))
		else $error("LED index out of range");

	// A tick request never reports an error.
	a_tick_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && !req.action) |=> !err_q)
		else $error("error flag set by a tick");

endmodule

### hdl/mlpc_apb_regs.sv
// APB configuration registers holding the blink and pulse periods.
module mlpc_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mlpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [mlpc_pkg::DATA_W-1:0]  pwdata,
	output logic [mlpc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output mlpc_pkg::cfg_t               cfg
);
	import mlpc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_period   <= SLOW_RST;
			cfg_q.normal_period <= NORMAL_RST;
			cfg_q.fast_period   <= FAST_RST;
			cfg_q.pulse_period  <= PULSE_RST;
		end else if (wr_en) begin
			case (sel)
				REG_SLOW:   cfg_q.slow_period   <= pwdata[PERIOD_W-1:0];
				REG_NORMAL: cfg_q.normal_period <= pwdata[PERIOD_W-1:0];
				REG_FAST:   cfg_q.fast_period   <= pwdata[PERIOD_W-1:0];
				REG_PULSE:  cfg_q.pulse_period  <= pwdata[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_SLOW:   prdata = DATA_W'(cfg_q.slow_period);
			REG_NORMAL: prdata = DATA_W'(cfg_q.normal_period);
			REG_FAST:   prdata = DATA_W'(cfg_q.fast_period);
			REG_PULSE:  prdata = DATA_W'(cfg_q.pulse_period);
			default:    prdata = '0;
		endcase
	end

endmodule

### hdl/mlpc_mod.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module mlpc_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mlpc_pkg::COUNT_W-1:0]  dividend,
	input  logic [mlpc_pkg::PULSE_W-1:0]  divisor,
	output logic                          done,
	output logic [mlpc_pkg::PULSE_W-1:0]  remainder
);
	import mlpc_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [COUNT_W-1:0]  dvd_q;
	logic [PULSE_W-1:0]  dsr_q;
	logic [PULSE_W-1:0]  rem_q;
	logic [PULSE_W:0]    trial;
	logic [PULSE_W-1:0]  rem_next;

	// Shift in the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial = {rem_q, dvd_q[COUNT_W-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = PULSE_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[PULSE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(COUNT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COUNT_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### test/multi_led_pattern_controller_tb.sv
// Testbench of the multi-LED pattern controller: directed and random LED commands against a predictor.
module multi_led_pattern_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mlpc_pkg::*;

	localparam int NUM_LEDS = 8;

	// The package gives no names to the two request kinds, so they live here.
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_SET  = 1'b1;

	// The cycle limit covers the whole run many times over, also with heavy
	// stalls on both sides.
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 11 * NUM_LEDS + 4;

	typedef struct packed {
		logic                 action;
		logic [IDX_FLD_W-1:0] led_index;
		mode_t                mode;
	} led_cmd_t;

	typedef struct packed {
		logic [LVL_W-1:0] led_levels;
		logic             error;
	} led_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	mlpc_req_if req_ch ();
	mlpc_rsp_if rsp_ch ();

	multi_led_pattern_controller #(
		.NUM_LEDS(NUM_LEDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Commands waiting to be offered to the block, and the LED levels that the
	// accepted ones must produce, oldest first.
	led_cmd_t    led_cmds_pending[$];
	led_result_t levels_due[$];

	int   req_gap_pct   = 0;
	int   rsp_stall_pct = 0;
	logic req_taken     = 1'b0;
	int   mismatches    = 0;
	int   cycle_count   = 0;

	// Shadow of the period registers and of the per-LED state.
	cfg_t        cfg_shadow;
	mode_t       led_mode[NUM_LEDS];
	logic [8:0]  tick_count[NUM_LEDS];
	logic        toggle_level[NUM_LEDS];
	logic        pin_level[NUM_LEDS];

	task automatic flag_mismatch(string what);
		mismatches++;
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
	endtask

	// Flipping the toggle level always drives the pin with it.
	function automatic void flip_led(int i);
		toggle_level[i] = ~toggle_level[i];
		pin_level[i] = toggle_level[i];
	endfunction

	// One tick for one LED. A period register holding zero behaves as one.
	function automatic void advance_led(int i);
		int         per;
		int         pulses;
		logic [8:0] cnt;
		case (led_mode[i])
			MODE_OFF: pin_level[i] = 1'b0;
			MODE_ON:  pin_level[i] = 1'b1;
			MODE_SLOW, MODE_NORMAL, MODE_FAST: begin
				per = (led_mode[i] == MODE_SLOW)   ? int'(cfg_shadow.slow_period) :
				      (led_mode[i] == MODE_NORMAL) ? int'(cfg_shadow.normal_period) :
				                                     int'(cfg_shadow.fast_period);
				if (per == 0) per = 1;
				cnt = tick_count[i] + 9'd1;
				if (int'(cnt) >= per) begin
					cnt = '0;
					flip_led(i);
				end
				tick_count[i] = cnt;
			end
			default: begin
				// Once, twice and thrice: toggle on every multiple of the pulse
				// period and drop to off after two periods per pulse. The pin
				// keeps its level until the following tick drives it low.
				pulses = int'(led_mode[i]) - int'(MODE_ONCE) + 1;
				per = int'(cfg_shadow.pulse_period);
				if (per == 0) per = 1;
				cnt = tick_count[i] + 9'd1;
				if (int'(cnt) % per == 0) flip_led(i);
				if (int'(cnt) >= 2 * per * pulses) begin
					cnt = '0;
					led_mode[i] = MODE_OFF;
				end
				tick_count[i] = cnt;
			end
		endcase
	endfunction

	// Applies one accepted command to the shadow state and returns the result
	// that the block owes for it. A set-mode command never touches the pins.
	function automatic led_result_t step_leds(led_cmd_t c);
		led_result_t r;
		r.error = 1'b0;
		if (c.action == ACT_SET) begin
			if (int'(c.led_index) < NUM_LEDS) begin
				led_mode[c.led_index] = c.mode;
				tick_count[c.led_index] = '0;
			end else begin
				r.error = 1'b1;
			end
		end else begin
			for (int i = 0; i < NUM_LEDS; i++) advance_led(i);
		end
		r.led_levels = '0;
		for (int i = 0; i < NUM_LEDS && i < LVL_W; i++) r.led_levels[i] = pin_level[i];
		return r;
	endfunction

	// Request driver. Inputs change on the falling edge only; an offered
	// command is held until the block takes it.
	always @(negedge clk) begin
		led_cmd_t nxt;
		logic     taken_now;
		logic     drive;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			taken_now = req_taken;
			if (req_taken) begin
				nxt = led_cmds_pending.pop_front();
				req_taken = 1'b0;
			end
			drive = req_ch.valid && !taken_now;
			if (!drive && led_cmds_pending.size() != 0)
				drive = ($urandom_range(99) >= req_gap_pct);
			if (drive) begin
				nxt = led_cmds_pending[0];
				req_ch.valid     <= 1'b1;
				req_ch.action    <= nxt.action;
				req_ch.led_index <= nxt.led_index;
				req_ch.mode      <= nxt.mode;
			end else begin
				req_ch.valid <= 1'b0;
			end
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Monitor: responses are checked before the new request is predicted, so
	// a response and a request on the same edge cannot be paired wrongly.
	always @(posedge clk) begin
		led_cmd_t    cmd;
		led_result_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycle_count);
				$display("Test completed with failures");
				$finish;
			end else begin
				if (rsp_ch.valid && rsp_ch.ready) begin
					if (levels_due.size() == 0) begin
						flag_mismatch($sformatf("unrequested response: levels %02h error %0b",
							rsp_ch.led_levels, rsp_ch.error));
					end else begin
						want = levels_due.pop_front();
						if (rsp_ch.led_levels !== want.led_levels)
							flag_mismatch($sformatf("led_levels %02h, expected %02h",
								rsp_ch.led_levels, want.led_levels));
						if (rsp_ch.error !== want.error)
							flag_mismatch($sformatf("error %0b, expected %0b",
								rsp_ch.error, want.error));
					end
				end
				if (req_ch.valid && req_ch.ready) begin
					cmd.action    = req_ch.action;
					cmd.led_index = req_ch.led_index;
					cmd.mode      = mode_t'(req_ch.mode);
					levels_due.push_back(step_leds(cmd));
					req_taken = 1'b1;
				end
			end
		end
	end

	task automatic queue_cmd(logic action, int idx, mode_t m);
		led_cmd_t c;
		c.action    = action;
		c.led_index = IDX_FLD_W'(idx);
		c.mode      = m;
		led_cmds_pending.push_back(c);
	endtask

	// Most traffic is a few mode changes on real LEDs followed by a run of
	// ticks long enough for the blink and pulse patterns to play out. The
	// rest is bad indexes and fully random commands. Tick commands carry
	// random index and mode fields, which the block must ignore.
	task automatic queue_random_cmds(int count);
		int added;
		int kind;
		int n;
		added = 0;
		while (added < count) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				n = $urandom_range(1, 3);
				repeat (n) queue_cmd(ACT_SET, $urandom_range(NUM_LEDS - 1),
					mode_t'($urandom_range(7)));
				added += n;
				n = $urandom_range(1, 14);
				repeat (n) queue_cmd(ACT_TICK, $urandom_range(15), mode_t'($urandom_range(7)));
				added += n;
			end else if (kind < 85) begin
				queue_cmd(ACT_SET, $urandom_range(NUM_LEDS, 15), mode_t'($urandom_range(7)));
				added++;
			end else begin
				queue_cmd(logic'($urandom_range(1)), $urandom_range(15),
					mode_t'($urandom_range(7)));
				added++;
			end
		end
	endtask

	// Waits until every command is taken and every result has come back.
	task automatic wait_idle();
		do @(negedge clk);
		while (led_cmds_pending.size() != 0 || levels_due.size() != 0 || req_ch.valid);
	endtask

	task automatic apb_access(reg_idx_t which, logic write, logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {which, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		// Writes keep only the register's own width.
		case (which)
			REG_SLOW: begin
				if (write) cfg_shadow.slow_period = data[PERIOD_W-1:0];
				want = DATA_W'(cfg_shadow.slow_period);
			end
			REG_NORMAL: begin
				if (write) cfg_shadow.normal_period = data[PERIOD_W-1:0];
				want = DATA_W'(cfg_shadow.normal_period);
			end
			REG_FAST: begin
				if (write) cfg_shadow.fast_period = data[PERIOD_W-1:0];
				want = DATA_W'(cfg_shadow.fast_period);
			end
			default: begin
				if (write) cfg_shadow.pulse_period = data[PULSE_W-1:0];
				want = DATA_W'(cfg_shadow.pulse_period);
			end
		endcase
		if (!write && prdata !== want)
			flag_mismatch($sformatf("register %s reads %0h, expected %0h",
				which.name(), prdata, want));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Writes all four periods, then reads each one back.
	task automatic set_periods(logic [DATA_W-1:0] slow_v, logic [DATA_W-1:0] normal_v,
		logic [DATA_W-1:0] fast_v, logic [DATA_W-1:0] pulse_v);
		apb_access(REG_SLOW, 1'b1, slow_v);
		apb_access(REG_NORMAL, 1'b1, normal_v);
		apb_access(REG_FAST, 1'b1, fast_v);
		apb_access(REG_PULSE, 1'b1, pulse_v);
		apb_access(REG_SLOW, 1'b0, '0);
		apb_access(REG_NORMAL, 1'b0, '0);
		apb_access(REG_FAST, 1'b0, '0);
		apb_access(REG_PULSE, 1'b0, '0);
	endtask

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.action    = ACT_TICK;
		req_ch.led_index = '0;
		req_ch.mode      = MODE_OFF;
		rsp_ch.ready     = 1'b0;
		cfg_shadow.slow_period   = SLOW_RST;
		cfg_shadow.normal_period = NORMAL_RST;
		cfg_shadow.fast_period   = FAST_RST;
		cfg_shadow.pulse_period  = PULSE_RST;
		for (int i = 0; i < NUM_LEDS; i++) begin
			led_mode[i]     = MODE_OFF;
			tick_count[i]   = '0;
			toggle_level[i] = 1'b0;
			pin_level[i]    = 1'b0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset periods, with no idling. The reads check
		// the reset values of the registers.
		apb_access(REG_SLOW, 1'b0, '0);
		apb_access(REG_NORMAL, 1'b0, '0);
		apb_access(REG_FAST, 1'b0, '0);
		apb_access(REG_PULSE, 1'b0, '0);
		queue_cmd(ACT_TICK, 15, MODE_THRICE);
		// A set-mode request leaves the pins alone until the next tick.
		queue_cmd(ACT_SET, 0, MODE_ON);
		queue_cmd(ACT_SET, NUM_LEDS - 1, MODE_ON);
		queue_cmd(ACT_TICK, 0, MODE_OFF);
		// Indexes past the last LED answer with the error flag and change nothing.
		queue_cmd(ACT_SET, 15, MODE_THRICE);
		queue_cmd(ACT_SET, NUM_LEDS, MODE_ON);
		// Every mode at once; LED 0 goes from on to off, which must pull it low.
		queue_cmd(ACT_SET, 0, MODE_OFF);
		queue_cmd(ACT_SET, 1, MODE_FAST);
		queue_cmd(ACT_SET, 2, MODE_NORMAL);
		queue_cmd(ACT_SET, 3, MODE_SLOW);
		queue_cmd(ACT_SET, 4, MODE_ONCE);
		queue_cmd(ACT_SET, 5, MODE_TWICE);
		queue_cmd(ACT_SET, 6, MODE_THRICE);
		// Enough ticks for the single pulse to end and fall back to off.
		for (int k = 0; k < 8; k++) queue_cmd(ACT_TICK, 15 - k, mode_t'(k));
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		// Short periods, no idling.
		set_periods(32'd3, 32'd2, 32'd1, 32'd1);
		queue_random_cmds(125);
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		// Zero periods, which must behave as one. Upper bits are set to show
		// that only the register width is kept. The sender idles often.
		set_periods(32'hFFFF_FF00, 32'h0000_0100, 32'h0000_0001, 32'h0000_00C0);
		req_gap_pct = 59;
		queue_random_cmds(125);
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		// Longest periods; the receiver stalls often.
		req_gap_pct = 0;
		set_periods(32'd255, 32'd255, 32'd255, 32'hFF);
		rsp_stall_pct = 59;
		queue_random_cmds(125);
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		// Random short periods with light idling on both sides. Halfway the
		// sender holds back until every result has come home.
		rsp_stall_pct = 0;
		set_periods($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
			$urandom_range(1, 3));
		req_gap_pct   = 17;
		rsp_stall_pct = 17;
		queue_random_cmds(60);
		wait_idle();
		queue_random_cmds(65);
		wait_idle();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && levels_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
